FILE: hdl/sgce_pkg.sv
// Shared types and constants for the saturated gain constraint evaluator.
package sgce_pkg;

    localparam logic [31:0] STEP_DT_RESET = 32'd4294967;

    localparam logic [1:0] REGION_WITHIN = 2'd0;
    localparam logic [1:0] REGION_BELOW  = 2'd1;
    localparam logic [1:0] REGION_ABOVE  = 2'd2;

    localparam logic signed [63:0] COST_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] COST_MIN = 64'sh8000_0000_0000_0000;

    typedef enum logic [1:0] {
        OP_ZERO_GAIN,
        OP_WITHIN,
        OP_SAT
    } sgce_op_t;

    typedef struct packed {
        sgce_op_t          op;
        logic [63:0]       opa;
        logic [31:0]       opb;
        logic              neg;
        logic [30:0]       gain;
        logic signed [31:0] impulse;
        logic [30:0]       hess;
        logic [1:0]        region;
        logic              last;
    } sgce_req_t;

endpackage

FILE: hdl/sgce_front.sv
// Front end: accepts items, forms y, classifies it and prepares the cost request.
module sgce_front import sgce_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [31:0]        step_dt,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [30:0]        s_gain,
    input  logic signed [31:0] s_bias,
    input  logic [30:0]        s_effort_limit,
    input  logic signed [31:0] s_velocity,
    input  logic               s_last,
    output logic               push_valid,
    input  logic               push_ready,
    output sgce_req_t          push_data
);

    typedef enum logic [2:0] {F_IDLE, F_MUL1, F_CLASS, F_MUL2, F_PUSH} fstate_t;

    fstate_t            state_reg;
    logic [30:0]        gain_reg;
    logic signed [31:0] bias_reg;
    logic [30:0]        limit_reg;
    logic signed [31:0] velocity_reg;
    logic               last_reg;
    logic signed [63:0] kv_reg;
    logic signed [63:0] y_reg;
    logic [1:0]         region_reg;
    logic signed [31:0] clamp_reg;
    logic signed [31:0] lim_reg;
    logic signed [64:0] dtc_reg;
    logic [62:0]        dtk_reg;
    logic [61:0]        ysq_reg;

    logic signed [63:0] y_next;
    logic signed [63:0] e_ext;
    logic signed [63:0] ymag_w;
    logic [30:0]        ym;
    logic signed [31:0] g;
    logic signed [32:0] g_ext;
    logic signed [32:0] gmag_w;
    logic signed [32:0] v_ext;
    logic signed [32:0] vmag_w;
    logic signed [63:0] d;
    logic signed [63:0] dmag_w;

    assign y_next = $signed({{32{bias_reg[31]}}, bias_reg}) - (kv_reg >>> FRAC_BITS);
    assign e_ext  = {33'b0, limit_reg};
    assign ymag_w = y_reg[63] ? -y_reg : y_reg;
    assign ym     = ymag_w[30:0];
    assign g      = dtc_reg[63:32];
    assign g_ext  = {g[31], g};
    assign gmag_w = g[31] ? -g_ext : g_ext;
    assign v_ext  = {velocity_reg[31], velocity_reg};
    assign vmag_w = velocity_reg[31] ? -v_ext : v_ext;
    assign d      = (y_reg <<< 1) - {{32{lim_reg[31]}}, lim_reg};
    assign dmag_w = d[63] ? -d : d;

    always_comb begin
        push_data         = '0;
        push_data.gain    = gain_reg;
        push_data.impulse = g;
        push_data.hess    = (region_reg == REGION_WITHIN) ? dtk_reg[62:32] : 31'd0;
        push_data.region  = region_reg;
        push_data.last    = last_reg;
        if (gain_reg == 31'd0) begin
            push_data.op  = OP_ZERO_GAIN;
            push_data.opa = {32'b0, vmag_w[31:0]};
            push_data.opb = gmag_w[31:0];
            push_data.neg = (g[31] == velocity_reg[31]);
        end else if (region_reg == REGION_WITHIN) begin
            push_data.op  = OP_WITHIN;
            push_data.opa = {2'b0, ysq_reg};
            push_data.opb = step_dt;
            push_data.neg = 1'b0;
        end else begin
            push_data.op  = OP_SAT;
            push_data.opa = dmag_w;
            push_data.opb = gmag_w[31:0];
            push_data.neg = (g[31] != d[63]);
        end
    end

    assign s_ready    = (state_reg == F_IDLE);
    assign push_valid = (state_reg == F_PUSH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        gain_reg     <= s_gain;
                        bias_reg     <= s_bias;
                        limit_reg    <= s_effort_limit;
                        velocity_reg <= s_velocity;
                        last_reg     <= s_last;
                        state_reg    <= F_MUL1;
                    end
                end
                F_MUL1: begin
                    kv_reg    <= $signed({1'b0, gain_reg}) * velocity_reg;
                    state_reg <= F_CLASS;
                end
                F_CLASS: begin
                    y_reg <= y_next;
                    if (y_next < -e_ext) begin
                        region_reg <= REGION_BELOW;
                        clamp_reg  <= -$signed({1'b0, limit_reg});
                        lim_reg    <= -$signed({1'b0, limit_reg});
                    end else if (y_next > e_ext) begin
                        region_reg <= REGION_ABOVE;
                        clamp_reg  <= $signed({1'b0, limit_reg});
                        lim_reg    <= $signed({1'b0, limit_reg});
                    end else begin
                        region_reg <= REGION_WITHIN;
                        clamp_reg  <= y_next[31:0];
                        lim_reg    <= 32'sd0;
                    end
                    state_reg <= F_MUL2;
                end
                F_MUL2: begin
                    dtc_reg   <= $signed({1'b0, step_dt}) * clamp_reg;
                    dtk_reg   <= step_dt * gain_reg;
                    ysq_reg   <= ym * ym;
                    state_reg <= F_PUSH;
                end
                F_PUSH: begin
                    if (push_ready) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/sgce_queue.sv
// Two-entry request queue between front and back.
module sgce_queue import sgce_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push_valid,
    output logic      push_ready,
    input  sgce_req_t push_data,
    output logic      pop_valid,
    input  logic      pop_ready,
    output sgce_req_t pop_data
);

    sgce_req_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

FILE: hdl/sgce_back.sv
// Back end: cost multiply, iterative divide, saturation, accumulation, output register.
module sgce_back import sgce_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          pop_valid,
    output logic          pop_ready,
    input  sgce_req_t     pop_data,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [31:0]   m_impulse,
    output logic [30:0]   m_hess,
    output logic [1:0]    m_region,
    output logic [63:0]   m_element_cost,
    output logic [63:0]   m_running_cost,
    output logic          m_last
);

    localparam int ZG_LEFT  = (2 * FRAC_BITS >= 32) ? 0 : 32 - 2 * FRAC_BITS;
    localparam int ZG_RIGHT = (2 * FRAC_BITS >= 32) ? 2 * FRAC_BITS - 32 : 0;
    localparam int WI_RIGHT = FRAC_BITS + 1;
    localparam int SA_LEFT  = 31 - FRAC_BITS;

    typedef enum logic [2:0] {B_IDLE, B_MUL0, B_MUL1, B_SHIFT, B_PREP, B_DIV, B_DONE} bstate_t;

    bstate_t            state_reg;
    sgce_req_t          req_reg;
    logic [63:0]        pp0_reg;
    logic [63:0]        pp1_reg;
    logic [127:0]       n_reg;
    logic [31:0]        rem_reg;
    logic [63:0]        num_reg;
    logic               ovf_reg;
    logic [4:0]         cnt_reg;
    logic               m_valid_reg;
    logic [31:0]        impulse_reg;
    logic [30:0]        hess_reg;
    logic [1:0]         region_reg;
    logic signed [63:0] cost_reg;
    logic signed [63:0] running_reg;
    logic               last_reg;
    logic signed [63:0] acc_reg;

    logic [127:0]       wide;
    logic [127:0]       shifted;
    logic [31:0]        k32;
    logic [31:0]        t1;
    logic [31:0]        r1;
    logic [31:0]        t2;
    logic [31:0]        r2;
    logic               q1;
    logic               q2;
    logic signed [63:0] cost_next;
    logic signed [64:0] sum;
    logic signed [63:0] acc_sum;
    logic               load;

    assign wide = {32'b0, pp1_reg, 32'b0} + {64'b0, pp0_reg};

    always_comb begin
        case (req_reg.op)
            OP_ZERO_GAIN: shifted = (wide << ZG_LEFT) >> ZG_RIGHT;
            OP_WITHIN:    shifted = wide >> WI_RIGHT;
            OP_SAT:       shifted = wide << SA_LEFT;
            default:      shifted = wide;
        endcase
    end

    assign k32 = {1'b0, req_reg.gain};
    assign t1  = {rem_reg[30:0], num_reg[63]};
    assign q1  = (t1 >= k32);
    assign r1  = q1 ? t1 - k32 : t1;
    assign t2  = {r1[30:0], num_reg[62]};
    assign q2  = (t2 >= k32);
    assign r2  = q2 ? t2 - k32 : t2;

    always_comb begin
        if (ovf_reg || num_reg[63]) begin
            cost_next = req_reg.neg ? COST_MIN : COST_MAX;
        end else begin
            cost_next = req_reg.neg ? -$signed(num_reg) : $signed(num_reg);
        end
    end

    assign sum     = {acc_reg[63], acc_reg} + {cost_next[63], cost_next};
    assign acc_sum = (sum[64] != sum[63]) ? (sum[64] ? COST_MIN : COST_MAX) : sum[63:0];
    assign load    = (state_reg == B_DONE) && (!m_valid_reg || m_ready);

    assign pop_ready      = (state_reg == B_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_impulse      = impulse_reg;
    assign m_hess         = hess_reg;
    assign m_region       = region_reg;
    assign m_element_cost = cost_reg;
    assign m_running_cost = running_reg;
    assign m_last         = last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
            acc_reg     <= 64'sd0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                impulse_reg <= req_reg.impulse;
                hess_reg    <= req_reg.hess;
                region_reg  <= req_reg.region;
                cost_reg    <= cost_next;
                running_reg <= acc_sum;
                last_reg    <= req_reg.last;
                acc_reg     <= req_reg.last ? 64'sd0 : acc_sum;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                B_IDLE: begin
                    if (pop_valid) begin
                        req_reg   <= pop_data;
                        state_reg <= B_MUL0;
                    end
                end
                B_MUL0: begin
                    pp0_reg   <= req_reg.opa[31:0] * req_reg.opb;
                    state_reg <= B_MUL1;
                end
                B_MUL1: begin
                    pp1_reg   <= req_reg.opa[63:32] * req_reg.opb;
                    state_reg <= B_SHIFT;
                end
                B_SHIFT: begin
                    n_reg     <= shifted;
                    state_reg <= B_PREP;
                end
                B_PREP: begin
                    cnt_reg <= 5'd0;
                    rem_reg <= n_reg[95:64];
                    num_reg <= n_reg[63:0];
                    if (req_reg.op == OP_ZERO_GAIN) begin
                        ovf_reg   <= (n_reg[127:64] != 64'd0);
                        state_reg <= B_DONE;
                    end else begin
                        ovf_reg   <= (n_reg[127:64] >= {33'b0, req_reg.gain});
                        state_reg <= B_DIV;
                    end
                end
                B_DIV: begin
                    rem_reg <= r2;
                    num_reg <= {num_reg[61:0], q1, q2};
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31) begin
                        state_reg <= B_DONE;
                    end
                end
                B_DONE: begin
                    if (load) begin
                        state_reg <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

FILE: hdl/saturated_gain_constraint_eval_top.sv
// Top level of the saturated gain constraint evaluator.
// Input stream s_*: one velocity element per request with its gain, bias and
// effort limit; s_tlast marks the final element of the constraint set.
// Output stream m_*: one result per request, in order: impulse, Hessian
// diagonal, region, element cost and running cost; m_tlast echoes the flag and
// the running cost of that result is the total, after which the sum clears.
// cfg_we/cfg_wdata write the time step (unsigned Q0.32); write only while idle.
// Throughput is set by the back end, which takes a new request only after it
// has finished the last: a pop step, two multiply steps, a shift step, a setup
// step, a divider that retires two quotient bits per cycle against the gain and
// an output load step. The front end and a two-entry queue overlap with it.
// A zero-gain request skips the divider.
// Reset (aresetn low, synchronous) clears the queue, the cost sum and the
// output valid, and sets the time step to its default of about 1 ms.
// When the receiver stalls, the result holds in the output register, the back
// end finishes its current request, the queue fills and s_tready drops.
module saturated_gain_constraint_eval_top import sgce_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // gain[30:0], bias[62:31], effort_limit[93:63], velocity[125:94], zero
    input  logic [127:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // impulse[31:0], hessian_diag[62:32], region[64:63],
    // element_cost[128:65], running_cost[192:129], zero
    output logic [199:0] m_tdata,
    output logic         m_tlast
);

    logic [31:0] step_dt_reg;
    logic        push_valid;
    logic        push_ready;
    sgce_req_t   push_data;
    logic        pop_valid;
    logic        pop_ready;
    sgce_req_t   pop_data;
    logic [31:0] impulse;
    logic [30:0] hess;
    logic [1:0]  region;
    logic [63:0] element_cost;
    logic [63:0] running_cost;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_dt_reg <= STEP_DT_RESET;
        end else if (cfg_we) begin
            step_dt_reg <= cfg_wdata;
        end
    end

    sgce_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_dt        (step_dt_reg),
        .s_valid        (s_tvalid),
        .s_ready        (s_tready),
        .s_gain         (s_tdata[30:0]),
        .s_bias         (s_tdata[62:31]),
        .s_effort_limit (s_tdata[93:63]),
        .s_velocity     (s_tdata[125:94]),
        .s_last         (s_tlast),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_data      (push_data)
    );

    sgce_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    sgce_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_data       (pop_data),
        .m_valid        (m_tvalid),
        .m_ready        (m_tready),
        .m_impulse      (impulse),
        .m_hess         (hess),
        .m_region       (region),
        .m_element_cost (element_cost),
        .m_running_cost (running_cost),
        .m_last         (m_tlast)
    );

    assign m_tdata = {7'b0, running_cost, element_cost, region, hess, impulse};

endmodule

FILE: hdl/sgce_checker.sv
// Port-level checker for the evaluator, bound to the top level.
module sgce_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [199:0] m_tdata,
    input logic         m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result dropped or changed under stall");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_region: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[64:63] != 2'd3)
        else $error("bad region code");

    a_hess: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[64:63] != 2'd0 |-> m_tdata[62:32] == 31'd0)
        else $error("Hessian diagonal nonzero while saturated");

endmodule

bind saturated_gain_constraint_eval_top sgce_checker u_sgce_checker (.*);
